[rtl/core/qmorg_pkg.sv]
// shared types and constants for the quote move order risk gate
// no dependencies; imported by every module of the block
package qmorg_pkg;

   localparam int INST_W      = 6;
   localparam int TIME_W      = 63;
   localparam int PRICE_W     = 32;
   localparam int QTY_W       = 16;
   localparam int VOL_W       = 16;
   localparam int POS_LIMIT_W = 31;
   localparam int WIN_W       = 34;
   localparam int POS_W       = 32;
   localparam int FILL_CNT_W  = 32;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME_LIMIT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_LIMIT = CSR_IDX_W'(1);

   localparam logic MODE_QUOTE = 1'b0;
   localparam logic MODE_FILL  = 1'b1;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   // one instrument's book entry as kept in the state memory
   typedef struct packed {
      logic [PRICE_W-1:0]      prev_bid;
      logic [PRICE_W-1:0]      prev_ask;
      logic                    prev_valid;
      logic signed [POS_W-1:0] position;
      logic [VOL_W-1:0]        window_volume;
      logic [WIN_W-1:0]        window_index;
      logic                    order_active;
      logic                    order_size;
      logic [FILL_CNT_W-1:0]   filled_count;
   } entry_type;

   // an accepted item waiting for its entry
   typedef struct packed {
      logic               mode;
      logic [INST_W-1:0]  instrument;
      logic               in_range;
      logic [WIN_W-1:0]   win;
      logic               quote_valid;
      logic [PRICE_W-1:0] bid_price;
      logic [PRICE_W-1:0] ask_price;
      logic [QTY_W-1:0]   fill_qty;
      logic               fill_side;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic               side;
   } order_type;

endpackage

[rtl/core/qmorg_state_mem.sv]
// per-instrument state memory: one write port, one registered read port
// forwards the most recent write onto the read data; uses qmorg_pkg
module qmorg_state_mem #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output qmorg_pkg::entry_type  rd_data,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  qmorg_pkg::entry_type  wr_data
);
   import qmorg_pkg::*;

   entry_type        mem [DEPTH];
   entry_type        rd_data_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic             last_wr_valid_ff;
   logic             last_wr_valid_in;
   logic [IDX_W-1:0] last_wr_addr_ff;
   entry_type        last_wr_data_ff;

   // read returns the old contents when the same entry is written that edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         last_wr_addr_ff <= wr_addr;
         last_wr_data_ff <= wr_data;
      end
   end

   // any write, clearing writes included, becomes the forwarding source
   always_comb begin
      last_wr_valid_in = last_wr_valid_ff;
      if (wr_en) begin
         last_wr_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_wr_valid_ff <= 1'b0;
      end else begin
         last_wr_valid_ff <= last_wr_valid_in;
      end
   end

   assign rd_data = (last_wr_valid_ff && (last_wr_addr_ff == rd_addr_ff)) ?
                    last_wr_data_ff : rd_data_ff;

endmodule

[rtl/core/qmorg_exec.sv]
// update of one book entry for one item: quote compare, risk checks, fills
// purely combinational, sits between the memory read and the write-back; uses qmorg_pkg
module qmorg_exec (
   input  qmorg_pkg::item_type              item,
   input  qmorg_pkg::entry_type             entry_cur,
   input  logic [qmorg_pkg::VOL_W-1:0]      volume_limit,
   input  logic [qmorg_pkg::POS_LIMIT_W-1:0] position_limit,
   output qmorg_pkg::entry_type             entry_next,
   output qmorg_pkg::order_type             order
);
   import qmorg_pkg::*;

   typedef struct packed {
      logic      ok;
      entry_type entry;
   } attempt_type;

   localparam logic signed [POS_W+1:0] POS_HI = {3'b000, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W+1:0] POS_LO = {3'b111, {(POS_W-1){1'b0}}};

   function automatic attempt_type try_order(
      entry_type                s,
      logic [WIN_W-1:0]         win,
      logic                     sell,
      logic [VOL_W-1:0]         vl,
      logic [POS_LIMIT_W-1:0]   pl
   );
      attempt_type             r;
      logic [VOL_W:0]          vol_next;
      logic signed [POS_W:0]   after;
      logic [POS_W:0]          mag;
      r.ok    = 1'b0;
      r.entry = s;
      if (!s.order_active) begin
         // a new window starts the volume count over
         if (s.window_index != win) begin
            r.entry.window_volume = '0;
            r.entry.window_index  = win;
         end
         vol_next = {1'b0, r.entry.window_volume} + (VOL_W+1)'(1);
         if (sell) begin
            after = {s.position[POS_W-1], s.position} - (POS_W+1)'(1);
         end else begin
            after = {s.position[POS_W-1], s.position} + (POS_W+1)'(1);
         end
         mag = after[POS_W] ? $unsigned(-after) : $unsigned(after);
         if ((vol_next <= {1'b0, vl}) && (mag <= {2'b00, pl})) begin
            r.ok                  = 1'b1;
            r.entry.window_volume = vol_next[VOL_W-1:0];
            r.entry.order_active  = 1'b1;
            r.entry.order_size    = 1'b1;
            r.entry.filled_count  = '0;
         end
      end
      return r;
   endfunction

   logic                    sell_try;
   logic                    buy_try;
   attempt_type             sell_res;
   attempt_type             buy_res;
   logic                    sell_ok;
   logic                    buy_ok;
   entry_type               after_sell;
   entry_type               quote_entry;
   entry_type               fill_entry;
   logic signed [POS_W+1:0] pos_ext;
   logic signed [POS_W+1:0] fill_sum;
   logic [FILL_CNT_W-1:0]   filled_sum;

   always_comb begin
      sell_try = item.quote_valid && entry_cur.prev_valid &&
                 (item.bid_price > entry_cur.prev_bid);
      buy_try  = item.quote_valid && entry_cur.prev_valid &&
                 (item.ask_price < entry_cur.prev_ask);

      // sell goes first; a sent sell blocks the buy as a working order
      sell_res   = try_order(entry_cur, item.win, SIDE_SELL, volume_limit, position_limit);
      sell_ok    = sell_try && sell_res.ok;
      after_sell = sell_try ? sell_res.entry : entry_cur;

      buy_res     = try_order(after_sell, item.win, SIDE_BUY, volume_limit, position_limit);
      buy_ok      = buy_try && !sell_ok && buy_res.ok;
      quote_entry = (buy_try && !sell_ok) ? buy_res.entry : after_sell;
      quote_entry.prev_bid   = item.bid_price;
      quote_entry.prev_ask   = item.ask_price;
      quote_entry.prev_valid = item.quote_valid;

      // fill: saturating position, wrapping filled count
      pos_ext = {{2{entry_cur.position[POS_W-1]}}, entry_cur.position};
      if (item.fill_side == SIDE_SELL) begin
         fill_sum = pos_ext - (POS_W+2)'(item.fill_qty);
      end else begin
         fill_sum = pos_ext + (POS_W+2)'(item.fill_qty);
      end
      fill_entry = entry_cur;
      priority if (fill_sum > POS_HI) begin
         fill_entry.position = POS_HI[POS_W-1:0];
      end else if (fill_sum < POS_LO) begin
         fill_entry.position = POS_LO[POS_W-1:0];
      end else begin
         fill_entry.position = fill_sum[POS_W-1:0];
      end
      filled_sum = entry_cur.filled_count + FILL_CNT_W'(item.fill_qty);
      fill_entry.filled_count = filled_sum;
      if (filled_sum == FILL_CNT_W'(entry_cur.order_size)) begin
         fill_entry.order_active = 1'b0;
      end

      order.valid = 1'b0;
      order.price = sell_ok ? item.bid_price : item.ask_price;
      order.side  = sell_ok ? SIDE_SELL : SIDE_BUY;
      unique case (item.mode)
         MODE_QUOTE: begin
            entry_next  = quote_entry;
            order.valid = sell_ok || buy_ok;
         end
         MODE_FILL: begin
            entry_next = fill_entry;
         end
      endcase
   end

endmodule

[rtl/core/quote_move_order_risk_gate.sv]
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | mode, instrument, time, quote, fill
// rsp     | out       | rsp_valid / rsp_ready | order instrument, price, side, qty
// csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// one item per cycle while no result is stalled; an item waits in the update stage register,
// its order in the rsp register; the state memory read is registered, the update and write-back follow,
// the last write-back is forwarded onto a read of the same instrument
// after reset a clearing pass writes every entry, one a cycle, with req_ready low;
// an untaken result stalls the update stage and the input
// top level of the risk gate; uses qmorg_pkg, qmorg_state_mem and qmorg_exec
module quote_move_order_risk_gate #(
   parameter int NUM_INSTRUMENTS = 64,
   parameter int WINDOW_SHIFT    = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [qmorg_pkg::INST_W-1:0]        req_instrument,
   input  logic [qmorg_pkg::TIME_W-1:0]        req_event_time,
   input  logic                                req_quote_valid,
   input  logic [qmorg_pkg::PRICE_W-1:0]       req_bid_price,
   input  logic [qmorg_pkg::PRICE_W-1:0]       req_ask_price,
   input  logic [qmorg_pkg::QTY_W-1:0]         req_fill_qty,
   input  logic                                req_fill_side,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [qmorg_pkg::INST_W-1:0]        rsp_order_instrument,
   output logic [qmorg_pkg::PRICE_W-1:0]       rsp_order_price,
   output logic                                rsp_order_side,
   output logic                                rsp_order_qty,
   input  logic                                csr_wr_en,
   input  logic [qmorg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qmorg_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import qmorg_pkg::*;

   // only the first 64 instruments are addressable by the item field
   localparam int DEPTH = (NUM_INSTRUMENTS < (1 << INST_W)) ? NUM_INSTRUMENTS : (1 << INST_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [INST_W:0]  DEPTH_V  = (INST_W+1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   logic                   clearing_ff, clearing_in;
   logic [IDX_W-1:0]       clr_idx_ff, clr_idx_in;
   logic                   b_valid_ff, b_valid_in;
   item_type               b_item_ff, b_item_in;
   logic [IDX_W-1:0]       b_addr_ff, b_addr_in;
   logic [VOL_W-1:0]       volume_limit_ff, volume_limit_in;
   logic [POS_LIMIT_W-1:0] position_limit_ff, position_limit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INST_W-1:0]      rsp_inst_ff, rsp_inst_in;
   logic [PRICE_W-1:0]     rsp_price_ff, rsp_price_in;
   logic                   rsp_side_ff, rsp_side_in;

   logic                   req_fire;
   logic                   out_free;
   logic                   b_fire;
   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   entry_type              mem_wr_data;
   entry_type              mem_rd_data;
   entry_type              exec_entry;
   order_type              exec_order;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign b_fire    = b_valid_ff && out_free;
   assign req_ready = !clearing_ff && (!b_valid_ff || b_fire);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (clearing_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_idx_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = b_fire && b_item_ff.in_range;
         mem_wr_addr = b_addr_ff;
         mem_wr_data = exec_entry;
      end
   end

   qmorg_state_mem #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_instrument[IDX_W-1:0]),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   qmorg_exec u_exec (
      .item           (b_item_ff),
      .entry_cur      (mem_rd_data),
      .volume_limit   (volume_limit_ff),
      .position_limit (position_limit_ff),
      .entry_next     (exec_entry),
      .order          (exec_order)
   );

   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end

      b_valid_in = b_valid_ff;
      b_item_in  = b_item_ff;
      b_addr_in  = b_addr_ff;
      if (b_fire) begin
         b_valid_in = 1'b0;
      end
      if (req_fire) begin
         b_valid_in           = 1'b1;
         b_addr_in            = req_instrument[IDX_W-1:0];
         b_item_in.mode       = req_mode;
         b_item_in.instrument = req_instrument;
         b_item_in.in_range   = ({1'b0, req_instrument} < DEPTH_V);
         b_item_in.win        = WIN_W'(req_event_time >> WINDOW_SHIFT);
         b_item_in.quote_valid = req_quote_valid;
         b_item_in.bid_price  = req_bid_price;
         b_item_in.ask_price  = req_ask_price;
         b_item_in.fill_qty   = req_fill_qty;
         b_item_in.fill_side  = req_fill_side;
      end

      volume_limit_in   = volume_limit_ff;
      position_limit_in = position_limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VOLUME_LIMIT:   volume_limit_in   = csr_wdata[VOL_W-1:0];
            CSR_POSITION_LIMIT: position_limit_in = csr_wdata[POS_LIMIT_W-1:0];
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_inst_in  = rsp_inst_ff;
      rsp_price_in = rsp_price_ff;
      rsp_side_in  = rsp_side_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (b_fire && b_item_ff.in_range && exec_order.valid) begin
         rsp_valid_in = 1'b1;
         rsp_inst_in  = b_item_ff.instrument;
         rsp_price_in = exec_order.price;
         rsp_side_in  = exec_order.side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff       <= 1'b1;
         clr_idx_ff        <= '0;
         b_valid_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         volume_limit_ff   <= '0;
         position_limit_ff <= '0;
      end else begin
         clearing_ff       <= clearing_in;
         clr_idx_ff        <= clr_idx_in;
         b_valid_ff        <= b_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         volume_limit_ff   <= volume_limit_in;
         position_limit_ff <= position_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      b_item_ff    <= b_item_in;
      b_addr_ff    <= b_addr_in;
      rsp_inst_ff  <= rsp_inst_in;
      rsp_price_ff <= rsp_price_in;
      rsp_side_ff  <= rsp_side_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_order_instrument = rsp_inst_ff;
   assign rsp_order_price      = rsp_price_ff;
   assign rsp_order_side       = rsp_side_ff;
   assign rsp_order_qty        = 1'b1;

endmodule

[tb/testbench.sv]
// self-checking testbench for quote_move_order_risk_gate: a book model predicts each order,
// a scoreboard compares every result item; depends on qmorg_pkg and the rtl of the block
module testbench;
   import qmorg_pkg::*;

   localparam int NUM_INST     = 64;
   localparam int WIN_SHIFT    = 30;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic signed [POS_W+1:0] POS_TOP    = 34'sd2147483647;
   localparam logic signed [POS_W+1:0] POS_BOTTOM = -34'sd2147483648;

   typedef struct {
      logic               mode;
      logic [INST_W-1:0]  instrument;
      logic [TIME_W-1:0]  event_time;
      logic               quote_valid;
      logic [PRICE_W-1:0] bid;
      logic [PRICE_W-1:0] ask;
      logic [QTY_W-1:0]   fill_qty;
      logic               fill_side;
   } tick_type;

   typedef struct {
      logic [INST_W-1:0]  instrument;
      logic [PRICE_W-1:0] price;
      logic               side;
      logic               qty;
   } due_order_type;

   class risk_gate_book;
      entry_type              books[NUM_INST];
      logic [VOL_W-1:0]       volume_limit;
      logic [POS_LIMIT_W-1:0] position_limit;
      due_order_type          orders_due[$];
      int                     mismatches;

      function new();
         foreach (books[i]) books[i] = '0;
         volume_limit   = '0;
         position_limit = '0;
         mismatches     = 0;
      endfunction

      function void set_limit(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_VOLUME_LIMIT) volume_limit = data[VOL_W-1:0];
         else position_limit = data[POS_LIMIT_W-1:0];
      endfunction

      // risk checks in turn: working order, window volume, absolute position
      function bit try_send(int n, logic [WIN_W-1:0] win, logic [PRICE_W-1:0] price,
                            logic side);
         logic signed [POS_W:0] after;
         logic [POS_W:0]        mag;
         due_order_type         o;
         if (books[n].order_active) return 0;
         if (books[n].window_index != win) begin
            books[n].window_volume = '0;
            books[n].window_index  = win;
         end
         if ({1'b0, books[n].window_volume} + 1 > {1'b0, volume_limit}) return 0;
         after = {books[n].position[POS_W-1], books[n].position};
         after = (side == SIDE_SELL) ? after - 1 : after + 1;
         mag = after[POS_W] ? -after : after;
         if (mag > {2'b0, position_limit}) return 0;
         books[n].window_volume = books[n].window_volume + 1'b1;
         books[n].order_active  = 1'b1;
         books[n].order_size    = 1'b1;
         books[n].filled_count  = '0;
         o.instrument = INST_W'(n);
         o.price      = price;
         o.side       = side;
         o.qty        = 1'b1;
         orders_due.push_back(o);
         return 1;
      endfunction

      function void note_tick(tick_type t);
         int                      n;
         logic [TIME_W-1:0]       shifted;
         logic signed [POS_W+1:0] pos;
         logic signed [POS_W+1:0] qty_s;
         bit                      sent;
         n = t.instrument;
         if (n >= NUM_INST) return;
         if (t.mode == MODE_QUOTE) begin
            shifted = t.event_time >> WIN_SHIFT;
            if (t.quote_valid && books[n].prev_valid) begin
               sent = 0;
               if (t.bid > books[n].prev_bid)
                  sent = try_send(n, shifted[WIN_W-1:0], t.bid, SIDE_SELL);
               if (!sent && t.ask < books[n].prev_ask)
                  sent = try_send(n, shifted[WIN_W-1:0], t.ask, SIDE_BUY);
            end
            books[n].prev_bid   = t.bid;
            books[n].prev_ask   = t.ask;
            books[n].prev_valid = t.quote_valid;
         end else begin
            pos   = {{2{books[n].position[POS_W-1]}}, books[n].position};
            qty_s = $signed((POS_W+2)'(t.fill_qty));
            pos   = (t.fill_side == SIDE_SELL) ? pos - qty_s : pos + qty_s;
            if (pos > POS_TOP) pos = POS_TOP;
            else if (pos < POS_BOTTOM) pos = POS_BOTTOM;
            books[n].position     = pos[POS_W-1:0];
            books[n].filled_count = books[n].filled_count + t.fill_qty;
            if (books[n].filled_count == FILL_CNT_W'(books[n].order_size))
               books[n].order_active = 1'b0;
         end
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task check_order(logic [INST_W-1:0] inst, logic [PRICE_W-1:0] price, logic side,
                       logic qty);
         due_order_type want;
         if (orders_due.size() == 0) begin
            report($sformatf("order with none due: instrument %0d price %0h side %0b",
                             inst, price, side));
            return;
         end
         want = orders_due.pop_front();
         if (inst !== want.instrument)
            report($sformatf("instrument %0d, expected %0d", inst, want.instrument));
         if (price !== want.price)
            report($sformatf("price %0h, expected %0h (instrument %0d)", price, want.price,
                             want.instrument));
         if (side !== want.side)
            report($sformatf("side %0b, expected %0b (instrument %0d)", side, want.side,
                             want.instrument));
         if (qty !== want.qty)
            report($sformatf("qty %0b, expected %0b (instrument %0d)", qty, want.qty,
                             want.instrument));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_mode;
   logic [INST_W-1:0]     req_instrument;
   logic [TIME_W-1:0]     req_event_time;
   logic                  req_quote_valid;
   logic [PRICE_W-1:0]    req_bid_price;
   logic [PRICE_W-1:0]    req_ask_price;
   logic [QTY_W-1:0]      req_fill_qty;
   logic                  req_fill_side;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [INST_W-1:0]     rsp_order_instrument;
   logic [PRICE_W-1:0]    rsp_order_price;
   logic                  rsp_order_side;
   logic                  rsp_order_qty;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   risk_gate_book     sb;
   logic [TIME_W-1:0] now_ns;
   int                cycles;
   int                ticks_sent;
   int                send_idle_pct;
   int                stall_pct;

   quote_move_order_risk_gate #(
      .NUM_INSTRUMENTS(NUM_INST),
      .WINDOW_SHIFT(WIN_SHIFT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_instrument(req_instrument),
      .req_event_time(req_event_time),
      .req_quote_valid(req_quote_valid),
      .req_bid_price(req_bid_price),
      .req_ask_price(req_ask_price),
      .req_fill_qty(req_fill_qty),
      .req_fill_side(req_fill_side),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_order_instrument(rsp_order_instrument),
      .rsp_order_price(rsp_order_price),
      .rsp_order_side(rsp_order_side),
      .rsp_order_qty(rsp_order_qty),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stalls, with a ready stretch every fourth block of cycles
   always @(negedge clock) begin
      rsp_ready <= ((cycles / 150) % 4 == 3) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_order(rsp_order_instrument, rsp_order_price, rsp_order_side, rsp_order_qty);
   end

   function automatic tick_type quote_tick(int inst, logic qv, logic [PRICE_W-1:0] bid,
                                           logic [PRICE_W-1:0] ask);
      tick_type t;
      t.mode        = MODE_QUOTE;
      t.instrument  = INST_W'(inst);
      t.event_time  = now_ns;
      t.quote_valid = qv;
      t.bid         = bid;
      t.ask         = ask;
      t.fill_qty    = QTY_W'($urandom);
      t.fill_side   = 1'($urandom);
      return t;
   endfunction

   function automatic tick_type fill_tick(int inst, logic [QTY_W-1:0] qty, logic side);
      tick_type t;
      t.mode        = MODE_FILL;
      t.instrument  = INST_W'(inst);
      t.event_time  = now_ns;
      t.quote_valid = 1'($urandom);
      t.bid         = $urandom;
      t.ask         = $urandom;
      t.fill_qty    = qty;
      t.fill_side   = side;
      return t;
   endfunction

   // mostly quote moves and matching fills on a few hot instruments, the rest noise
   function automatic tick_type random_tick();
      tick_type           t;
      int                 inst;
      int                 pick;
      entry_type          b;
      logic [PRICE_W-1:0] bid;
      logic [PRICE_W-1:0] ask;
      logic [QTY_W-1:0]   qty;
      logic               side;
      pick = $urandom_range(0, 99);
      if (pick < 75) now_ns = now_ns + $urandom_range(0, 1000);
      else if (pick < 97)
         now_ns = now_ns + (TIME_W'($urandom_range(1, 3)) << WIN_SHIFT) + $urandom;
      else now_ns = TIME_W'({$urandom, $urandom});
      inst = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      b = sb.books[inst];
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if (!b.prev_valid) begin
            bid = $urandom;
            ask = bid + $urandom_range(1, 1000);
         end else begin
            bid = b.prev_bid;
            ask = b.prev_ask;
            case ($urandom_range(0, 3))
               0: bid = bid + $urandom_range(1, 50);
               1: ask = ask - $urandom_range(1, 50);
               2: begin
                  bid = bid + $urandom_range(1, 50);
                  ask = ask - $urandom_range(1, 50);
               end
               default: begin
                  bid = bid - $urandom_range(0, 50);
                  ask = ask + $urandom_range(0, 50);
               end
            endcase
         end
         t = quote_tick(inst, 1'b1, bid, ask);
      end else if (pick < 78) begin
         // lean the fill side back toward a flat position
         side = 1'($urandom);
         if (b.position > 0 && $urandom_range(0, 3) != 0) side = SIDE_SELL;
         else if (b.position < 0 && $urandom_range(0, 3) != 0) side = SIDE_BUY;
         if (inst >= 48) begin
            pick = $urandom_range(0, 99);
            qty = (pick < 50) ? 16'd1 : (pick < 65) ? 16'd0 : 16'($urandom);
         end else if (b.order_active) begin
            qty = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'd1;
         end else begin
            qty = QTY_W'($urandom_range(0, 3));
         end
         t = fill_tick(inst, qty, side);
      end else if (pick < 90) begin
         t = quote_tick(inst, 1'b0, $urandom, $urandom);
      end else begin
         t = quote_tick(inst, 1'($urandom), $urandom, $urandom);
      end
      return t;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic push_tick(tick_type t);
      int gap_pct;
      gap_pct = ((ticks_sent / 40) % 4 == 3) ? 0 : send_idle_pct;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= t.mode;
      req_instrument  <= t.instrument;
      req_event_time  <= t.event_time;
      req_quote_valid <= t.quote_valid;
      req_bid_price   <= t.bid;
      req_ask_price   <= t.ask;
      req_fill_qty    <= t.fill_qty;
      req_fill_side   <= t.fill_side;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(t);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.orders_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_limit(idx, data);
      @(negedge clock);
   endtask

   task automatic run_directed();
      now_ns = '0;
      // plain sell, then both moves against a working order
      push_tick(quote_tick(5, 1'b1, 100, 200));
      push_tick(quote_tick(5, 1'b1, 101, 200));
      push_tick(quote_tick(5, 1'b1, 102, 199));
      push_tick(fill_tick(5, 1, SIDE_SELL));
      push_tick(quote_tick(5, 1'b1, 102, 150));
      push_tick(fill_tick(5, 0, SIDE_BUY));
      push_tick(fill_tick(5, 1, SIDE_BUY));
      // price extremes
      push_tick(quote_tick(5, 1'b1, 32'h0, 32'hFFFF_FFFF));
      push_tick(quote_tick(5, 1'b1, 32'hFFFF_FFFF, 32'h0));
      push_tick(fill_tick(5, 1, SIDE_SELL));
      // an invalid quote blocks the comparison on both sides of it
      push_tick(quote_tick(6, 1'b1, 10, 20));
      push_tick(quote_tick(6, 1'b0, 11, 19));
      push_tick(quote_tick(6, 1'b1, 12, 18));
      push_tick(quote_tick(6, 1'b1, 13, 17));
      push_tick(fill_tick(6, 1, SIDE_SELL));
      // zero fill with no order sent, then a zero fill on a working order
      push_tick(fill_tick(7, 0, SIDE_BUY));
      push_tick(quote_tick(7, 1'b1, 10, 20));
      push_tick(quote_tick(7, 1'b1, 11, 20));
      push_tick(fill_tick(7, 0, SIDE_SELL));
      push_tick(quote_tick(7, 1'b1, 12, 20));
      push_tick(fill_tick(7, 1, SIDE_SELL));
      // top of the time range
      now_ns = '1;
      push_tick(quote_tick(0, 1'b1, 500, 600));
      push_tick(quote_tick(0, 1'b1, 501, 600));
      push_tick(fill_tick(0, 16'hFFFF, SIDE_BUY));
      now_ns = 1000;
      // large fills push the highest instrument well long
      repeat (3) push_tick(fill_tick(63, 16'hFFFF, SIDE_BUY));
      push_tick(quote_tick(63, 1'b1, 100, 200));
      push_tick(quote_tick(63, 1'b1, 100, 150));
      push_tick(quote_tick(63, 1'b1, 101, 150));
      push_tick(fill_tick(63, 1, SIDE_SELL));
      // and then well short
      repeat (6) push_tick(fill_tick(63, 16'hFFFF, SIDE_SELL));
      push_tick(quote_tick(63, 1'b1, 102, 150));
      push_tick(quote_tick(63, 1'b1, 102, 140));
      push_tick(fill_tick(63, 1, SIDE_BUY));
   endtask

   initial begin
      int                     ph;
      int                     n_ticks;
      logic [VOL_W-1:0]       vol;
      logic [POS_LIMIT_W-1:0] pos;
      sb              = new();
      now_ns          = '0;
      cycles          = 0;
      ticks_sent      = 0;
      send_idle_pct   = 0;
      stall_pct       = 0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_QUOTE;
      req_instrument  = '0;
      req_event_time  = '0;
      req_quote_valid = 1'b0;
      req_bid_price   = '0;
      req_ask_price   = '0;
      req_fill_qty    = '0;
      req_fill_side   = SIDE_BUY;
      rsp_ready       = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_VOLUME_LIMIT;
      csr_wdata       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            0: begin
               vol = 16'hFFFF; pos = 31'h7FFF_FFFF;
               send_idle_pct = 0; stall_pct = 0; n_ticks = 250;
            end
            1: begin
               vol = 2; pos = 3;
               send_idle_pct = 81; stall_pct = 0; n_ticks = 280;
            end
            2: begin
               vol = 1; pos = 1;
               send_idle_pct = 0; stall_pct = 81; n_ticks = 280;
            end
            3: begin
               vol = 0; pos = 31'h7FFF_FFFF;
               send_idle_pct = 21; stall_pct = 21; n_ticks = 100;
            end
            4: begin
               vol = 16'hFFFF; pos = 0;
               send_idle_pct = 21; stall_pct = 21; n_ticks = 100;
            end
            5: begin
               vol = VOL_W'($urandom_range(1, 8));
               pos = POS_LIMIT_W'($urandom_range(1, 20));
               send_idle_pct = 21; stall_pct = 21; n_ticks = 280;
            end
            default: begin
               vol = 16'hFFFF; pos = 31'h7FFF_FFFF;
               send_idle_pct = 0; stall_pct = 0; n_ticks = 260;
            end
         endcase
         write_limit(CSR_VOLUME_LIMIT, CSR_DATA_W'(vol));
         write_limit(CSR_POSITION_LIMIT, pos);
         csr_wr_en <= 1'b0;
         @(negedge clock);
         if (ph == 0) run_directed();
         repeat (n_ticks) push_tick(random_tick());
      end
      drain();

      if (sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
